/* rtl/core/dwr_pkg.sv */
// ============================================================================
// dwr_pkg
// Shared types, codes and parameter defaults for the rotating deque.
// ============================================================================
`default_nettype none

package dwr_pkg;

    localparam int DEPTH_DEF      = 64;
    localparam int VALUE_BITS_DEF = 32;

    localparam int ACTION_W  = 3;
    localparam int WORD_W    = 32;
    localparam int STATUS_W  = 3;

    // Action codes carried in the input transfer.
    localparam logic [ACTION_W-1:0] ACT_PUSH_RIGHT = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_PUSH_LEFT  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_ROT_LEFT   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_ROT_RIGHT  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_DUMP       = 3'd4;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 3'd0,
        ST_FULL    = 3'd1,
        ST_IGNORED = 3'd2,
        ST_LISTED  = 3'd3,
        ST_EMPTY   = 3'd4
    } t_status;

    typedef struct packed {
        logic [ACTION_W-1:0]      action;
        logic signed [WORD_W-1:0] value;
    } t_in;

    typedef struct packed {
        t_status                  status;
        logic signed [WORD_W-1:0] element;
        logic                     last;
    } t_out;

endpackage

`default_nettype wire

/* rtl/core/dwr_mem.sv */
// ============================================================================
// dwr_mem
// Element store: one write port and one registered read port.
// ============================================================================
`default_nettype none

module dwr_mem #(
    parameter int DEPTH      = dwr_pkg::DEPTH_DEF,
    parameter int VALUE_BITS = dwr_pkg::VALUE_BITS_DEF,
    localparam int PTR_W     = $clog2(DEPTH)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_wr_en,
    input  wire logic [PTR_W-1:0]      i_wr_addr,
    input  wire logic [VALUE_BITS-1:0] i_wr_data,
    input  wire logic                  i_rd_en,
    input  wire logic [PTR_W-1:0]      i_rd_addr,
    output logic      [VALUE_BITS-1:0] o_rd_data
);

    logic [VALUE_BITS-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read data holds between enabled reads.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

/* rtl/core/deque_with_rotation.sv */
// ============================================================================
// deque_with_rotation
// Bounded double-ended queue of words with rotate and dump actions.
// ============================================================================
//
//  Channel  Direction  Handshake                 Payload
//  -------  ---------  ------------------------  ------------------------------
//  in       sink       i_in_valid / o_in_ready   i_in_data  (action, value)
//  out      source     o_out_valid / i_out_ready o_out_data (status, element, last)
//
// A push, a rejected action or an empty dump answers at once: its status is
// loaded into the output register at the edge that accepts the transfer.
// A rotation reads the moved word from the single read port in the idle state
// and writes it back through the write port in the rotate state.
// A dump of N words lists them one word per cycle from the read port while the
// output side does not stall.
// Reset is synchronous and clears the state, the front pointer, the fill count
// and the output valid; the store itself needs no clearing pass, since only
// occupied slots are ever read.
// ============================================================================
`default_nettype none

module deque_with_rotation #(
    parameter int DEPTH      = dwr_pkg::DEPTH_DEF,
    parameter int VALUE_BITS = dwr_pkg::VALUE_BITS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    output logic              o_in_ready,
    input  wire dwr_pkg::t_in i_in_data,
    output logic              o_out_valid,
    input  wire logic         i_out_ready,
    output dwr_pkg::t_out     o_out_data
);

    // Pointer into the circular store, and a count that can hold DEPTH itself.
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    localparam logic [CNT_W-1:0] OFF_ONE  = CNT_W'(1);
    localparam logic [CNT_W-1:0] OFF_TWO  = CNT_W'(2);
    localparam logic [CNT_W-1:0] OFF_LAST = CNT_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] OFF_ALL  = CNT_W'(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_ROT  = 3'b010,
        S_DUMP = 3'b100
    } t_state;

    // Slot of the word at a given offset from the front. The base stays below DEPTH
    // and the offset at most DEPTH, so one compare and subtract wraps the sum.
    function automatic logic [PTR_W-1:0] f_slot(input logic [PTR_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(off);
        if (sum >= SUM_W'(DEPTH)) begin
            sum = sum - SUM_W'(DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

    t_state            r_state, n_state;
    logic [PTR_W-1:0]  r_front, n_front;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_idx,   n_idx;
    logic [PTR_W-1:0]  r_dst,   n_dst;
    logic              r_out_valid, n_out_valid;
    dwr_pkg::t_out     r_out,   n_out;

    logic                  wr_en;
    logic [PTR_W-1:0]      wr_addr;
    logic [VALUE_BITS-1:0] wr_data;
    logic                  rd_en;
    logic [PTR_W-1:0]      rd_addr;
    logic [VALUE_BITS-1:0] rd_data;

    logic                  out_free;
    logic                  in_xfer;
    logic                  is_full;
    logic                  few_words;
    logic [VALUE_BITS+dwr_pkg::WORD_W-1:0] push_ext;
    logic [VALUE_BITS+dwr_pkg::WORD_W-1:0] read_ext;

    // The output register is free when empty or when its transfer completes now.
    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && out_free;
    assign in_xfer    = i_in_valid && o_in_ready;

    assign is_full   = (r_count == OFF_ALL);
    assign few_words = (r_count < OFF_TWO);

    // Words are stored as the low bits of the input word, zero above it, and
    // are listed back the same way.
    assign push_ext = {{VALUE_BITS{1'b0}}, i_in_data.value};
    assign read_ext = {{dwr_pkg::WORD_W{1'b0}}, rd_data};

    always_comb begin
        n_state     = r_state;
        n_front     = r_front;
        n_count     = r_count;
        n_idx       = r_idx;
        n_dst       = r_dst;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        wr_en       = 1'b0;
        wr_addr     = f_slot(r_front, r_count);
        wr_data     = push_ext[VALUE_BITS-1:0];
        rd_en       = 1'b0;
        rd_addr     = r_front;

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    // Most actions answer with one status result at once.
                    n_out_valid     = 1'b1;
                    n_out.status    = dwr_pkg::ST_DONE;
                    n_out.element   = '0;
                    n_out.last      = 1'b1;
                    case (i_in_data.action)
                        dwr_pkg::ACT_PUSH_RIGHT: begin
                            if (is_full) begin
                                n_out.status = dwr_pkg::ST_FULL;
                            end else begin
                                wr_en   = 1'b1;
                                n_count = r_count + OFF_ONE;
                            end
                        end
                        dwr_pkg::ACT_PUSH_LEFT: begin
                            if (is_full) begin
                                n_out.status = dwr_pkg::ST_FULL;
                            end else begin
                                wr_en   = 1'b1;
                                wr_addr = f_slot(r_front, OFF_LAST);
                                n_front = f_slot(r_front, OFF_LAST);
                                n_count = r_count + OFF_ONE;
                            end
                        end
                        dwr_pkg::ACT_ROT_LEFT: begin
                            if (few_words) begin
                                n_out.status = dwr_pkg::ST_IGNORED;
                            end else begin
                                // The front word is copied to the slot past the back.
                                rd_en   = 1'b1;
                                rd_addr = r_front;
                                n_dst   = f_slot(r_front, r_count);
                                n_front = f_slot(r_front, OFF_ONE);
                                n_state = S_ROT;
                            end
                        end
                        dwr_pkg::ACT_ROT_RIGHT: begin
                            if (few_words) begin
                                n_out.status = dwr_pkg::ST_IGNORED;
                            end else begin
                                // The back word is copied to the slot before the front.
                                rd_en   = 1'b1;
                                rd_addr = f_slot(r_front, r_count - OFF_ONE);
                                n_dst   = f_slot(r_front, OFF_LAST);
                                n_front = f_slot(r_front, OFF_LAST);
                                n_state = S_ROT;
                            end
                        end
                        dwr_pkg::ACT_DUMP: begin
                            if (r_count == '0) begin
                                n_out.status = dwr_pkg::ST_EMPTY;
                            end else begin
                                // Results come from the read port in the next state.
                                n_out_valid = 1'b0;
                                rd_en       = 1'b1;
                                rd_addr     = r_front;
                                n_idx       = '0;
                                n_state     = S_DUMP;
                            end
                        end
                        default: begin
                            // Undefined action codes change nothing.
                        end
                    endcase
                end
            end
            S_ROT: begin
                wr_en   = 1'b1;
                wr_addr = r_dst;
                wr_data = rd_data;
                n_state = S_IDLE;
            end
            S_DUMP: begin
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_out.status  = dwr_pkg::ST_LISTED;
                    n_out.element = read_ext[dwr_pkg::WORD_W-1:0];
                    n_out.last    = (r_idx + OFF_ONE == r_count);
                    if (r_idx + OFF_ONE == r_count) begin
                        n_state = S_IDLE;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = f_slot(r_front, r_idx + OFF_ONE);
                        n_idx   = r_idx + OFF_ONE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_dst <= n_dst;
        r_out <= n_out;
    end

    dwr_mem #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef ASSERT_OFF
    // The fill count never passes the store depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= OFF_ALL)
        else $error("fill count exceeds depth");

    // The write-back state of a rotation is always followed directly by idle.
    a_rot_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_ROT |=> r_state == S_IDLE)
        else $error("rotation write-back did not return to idle");

    // A dump of a non-empty store starts walking the store next cycle.
    a_dump_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && i_in_data.action == dwr_pkg::ACT_DUMP && r_count != '0
        |=> r_state == S_DUMP && !r_out_valid)
        else $error("dump did not enter the listing state");

    // The store does not change size while it is being listed.
    a_dump_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DUMP |=> $stable(r_count) && $stable(r_front))
        else $error("store changed during a dump");
`endif

endmodule

`default_nettype wire

/* tb/deque_checker.sv */
// ============================================================================
// deque_checker
// Tracks the rotating deque from its input transfers and checks its results.
// ============================================================================
`timescale 1ns / 100ps

module deque_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_ready,
    input  dwr_pkg::t_in  i_in_data,
    input  logic          i_out_valid,
    input  logic          i_out_ready,
    input  dwr_pkg::t_out i_out_data,
    output int            o_errors,
    output int            o_pending
);

    localparam int SLOTS = dwr_pkg::DEPTH_DEF;

    logic [dwr_pkg::WORD_W-1:0] word_store [SLOTS];
    int unsigned                head_slot;
    int unsigned                word_count;
    dwr_pkg::t_out              pending_results [$];
    int                         error_count;

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    function automatic int unsigned slot_at(input int unsigned offset);
        return (head_slot + offset) % SLOTS;
    endfunction

    function automatic dwr_pkg::t_out make_result(input dwr_pkg::t_status status,
                                                  input logic [dwr_pkg::WORD_W-1:0] word,
                                                  input logic is_last);
        dwr_pkg::t_out r;
        r.status  = status;
        r.element = word;
        r.last    = is_last;
        return r;
    endfunction

    // Updates the shadow deque for one accepted action and queues what it answers.
    task automatic apply_action(input dwr_pkg::t_in item);
        int unsigned src;
        int unsigned dst;
        case (item.action)
            dwr_pkg::ACT_PUSH_RIGHT, dwr_pkg::ACT_PUSH_LEFT: begin
                if (word_count >= SLOTS) begin
                    pending_results.push_back(make_result(dwr_pkg::ST_FULL, '0, 1'b1));
                end else begin
                    if (item.action == dwr_pkg::ACT_PUSH_RIGHT) begin
                        word_store[slot_at(word_count)] = item.value;
                    end else begin
                        head_slot = slot_at(SLOTS - 1);
                        word_store[head_slot] = item.value;
                    end
                    word_count++;
                    pending_results.push_back(make_result(dwr_pkg::ST_DONE, '0, 1'b1));
                end
            end
            dwr_pkg::ACT_ROT_LEFT, dwr_pkg::ACT_ROT_RIGHT: begin
                if (word_count < 2) begin
                    pending_results.push_back(make_result(dwr_pkg::ST_IGNORED, '0, 1'b1));
                end else begin
                    if (item.action == dwr_pkg::ACT_ROT_LEFT) begin
                        src = head_slot;
                        dst = slot_at(word_count);
                        word_store[dst] = word_store[src];
                        head_slot = slot_at(1);
                    end else begin
                        src = slot_at(word_count - 1);
                        dst = slot_at(SLOTS - 1);
                        word_store[dst] = word_store[src];
                        head_slot = dst;
                    end
                    pending_results.push_back(make_result(dwr_pkg::ST_DONE, '0, 1'b1));
                end
            end
            dwr_pkg::ACT_DUMP: begin
                if (word_count == 0) begin
                    pending_results.push_back(make_result(dwr_pkg::ST_EMPTY, '0, 1'b1));
                end else begin
                    for (int unsigned i = 0; i < word_count; i++) begin
                        pending_results.push_back(make_result(dwr_pkg::ST_LISTED,
                                                              word_store[slot_at(i)],
                                                              i + 1 == word_count));
                    end
                end
            end
            default: begin
                pending_results.push_back(make_result(dwr_pkg::ST_DONE, '0, 1'b1));
            end
        endcase
    endtask

    always @(posedge i_clk) begin : watch
        dwr_pkg::t_out want;
        dwr_pkg::t_out got;
        if (!i_rst_n) begin
            head_slot   = 0;
            word_count  = 0;
            error_count = 0;
            pending_results.delete();
        end else begin
            // Results come from a register, so one leaving now never belongs to
            // an action accepted at this same edge.
            if (i_out_valid && i_out_ready) begin
                got = i_out_data;
                if (pending_results.size() == 0) begin
                    error_count++;
                    $display("%0t ns: unexpected result: status %0d element %0d last %0d",
                             $time, got.status, got.element, got.last);
                end else begin
                    want = pending_results.pop_front();
                    if (got.status !== want.status || got.element !== want.element ||
                        got.last !== want.last) begin
                        error_count++;
                        $display("%0t ns: mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                                 $time, want.status, want.element, want.last,
                                 got.status, got.element, got.last);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                apply_action(i_in_data);
            end
        end
        o_errors  <= error_count;
        o_pending <= pending_results.size();
    end

endmodule

/* tb/testbench.sv */
// ============================================================================
// testbench
// Drives actions into the rotating deque with bursty input and a stalling
// output side, and reports the verdict from the checker's failure and pending counts.
// ============================================================================
`timescale 1ns / 100ps

module testbench;

    // Random actions after the directed opening; with roughly a third of them
    // pushes, the store fills up well before the end and stays full.
    localparam int RANDOM_ITEMS = 300;
    localparam int DRAIN_LIMIT  = 200000;

    logic          clk;
    logic          rst_n     = 1'b0;
    logic          in_valid  = 1'b0;
    logic          in_ready;
    dwr_pkg::t_in  in_data   = '0;
    logic          out_valid;
    logic          out_ready = 1'b0;
    dwr_pkg::t_out out_data;
    int            errors;
    int            pending;

    // Receiver pattern state: long stretches either stall freely or not at all.
    int   stall_left   = 0;
    int   stretch_left = 0;
    logic calm         = 1'b1;

    deque_with_rotation uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    deque_checker deque_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    // The slowest legal run is well under a millisecond; this only catches a hang.
    initial begin
        #4000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Output side.
    always @(posedge clk) begin
        if (stretch_left == 0) begin
            stretch_left <= $urandom_range(20, 150);
            calm         <= ($urandom_range(0, 2) == 0);
        end else begin
            stretch_left <= stretch_left - 1;
        end
        if (stall_left != 0) begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!calm && $urandom_range(0, 3) == 0) begin
            out_ready  <= 1'b0;
            stall_left <= $urandom_range(0, 6);
        end else begin
            out_ready <= 1'b1;
        end
    end

    // Presents one action and returns at the edge where its transfer happens.
    // Valid stays high on return so back-to-back actions need no extra edge.
    task automatic send_action(input logic [dwr_pkg::ACTION_W-1:0] action,
                               input logic [dwr_pkg::WORD_W-1:0] word);
        dwr_pkg::t_in item;
        item.action = action;
        item.value  = word;
        in_data  <= item;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic hold_off(input int cycles);
        if (cycles != 0) begin
            in_valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Lowers valid and waits until the checker has nothing outstanding. The
    // first edge lets the checker account for the transfer that just happened.
    task automatic wait_until_drained(input int limit);
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        do begin
            @(posedge clk);
            waited++;
        end while (pending != 0 && waited < limit);
    endtask

    function automatic logic [dwr_pkg::WORD_W-1:0] random_word();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'hFFFF_FFFF;
            3:       return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    // Pushes and rotations dominate so the deque grows through every size while
    // its order keeps changing; dumps list it at many fill levels along the way.
    function automatic logic [dwr_pkg::ACTION_W-1:0] random_action();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 18) return dwr_pkg::ACT_PUSH_RIGHT;
        if (pick < 35) return dwr_pkg::ACT_PUSH_LEFT;
        if (pick < 55) return dwr_pkg::ACT_ROT_LEFT;
        if (pick < 75) return dwr_pkg::ACT_ROT_RIGHT;
        if (pick < 88) return dwr_pkg::ACT_DUMP;
        // Unassigned codes act as no-ops.
        return dwr_pkg::ACTION_W'($urandom_range(5, 7));
    endfunction

    initial begin : stimulus
        int burst_left;
        burst_left = 0;
        do @(posedge clk); while (!rst_n);

        // Directed opening: rotations and a dump on an empty deque, then the
        // same on a single word, then word extremes at both ends with a left
        // push that wraps the front slot, rotations both ways, and the
        // unassigned action codes.
        send_action(dwr_pkg::ACT_ROT_LEFT, 32'h0000_0000);
        send_action(dwr_pkg::ACT_ROT_RIGHT, 32'hFFFF_FFFF);
        send_action(dwr_pkg::ACT_DUMP, 32'h0000_0000);
        send_action(dwr_pkg::ACT_PUSH_RIGHT, 32'h7FFF_FFFF);
        send_action(dwr_pkg::ACT_ROT_LEFT, 32'h1234_5678);
        send_action(dwr_pkg::ACT_ROT_RIGHT, 32'h0000_0000);
        send_action(dwr_pkg::ACT_DUMP, 32'h0000_0000);
        send_action(dwr_pkg::ACT_PUSH_LEFT, 32'h8000_0000);
        send_action(dwr_pkg::ACT_PUSH_RIGHT, 32'hFFFF_FFFF);
        send_action(dwr_pkg::ACT_PUSH_LEFT, 32'h0000_0000);
        send_action(dwr_pkg::ACT_DUMP, 32'h0000_0000);
        send_action(dwr_pkg::ACT_ROT_LEFT, 32'h0000_0000);
        send_action(dwr_pkg::ACT_ROT_RIGHT, 32'h0000_0000);
        send_action(dwr_pkg::ACT_ROT_RIGHT, 32'h0000_0000);
        send_action(dwr_pkg::ACT_DUMP, 32'h0000_0000);
        send_action(3'd5, 32'hFFFF_FFFF);
        send_action(3'd6, 32'h0000_0000);
        send_action(3'd7, 32'hFFFF_FFFF);
        send_action(dwr_pkg::ACT_PUSH_RIGHT, 32'h5555_5555);
        send_action(dwr_pkg::ACT_PUSH_LEFT, 32'hAAAA_AAAA);
        send_action(dwr_pkg::ACT_DUMP, 32'h0000_0000);

        // Let everything drain once before the random part starts.
        wait_until_drained(DRAIN_LIMIT);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (burst_left == 0) begin
                hold_off(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
                burst_left = $urandom_range(1, 16);
            end
            send_action(random_action(), random_word());
            burst_left--;
            if (n == RANDOM_ITEMS / 2) begin
                wait_until_drained(DRAIN_LIMIT);
            end
        end

        wait_until_drained(DRAIN_LIMIT);
        repeat (8) @(posedge clk);
        if (errors == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/core/dwr_pkg.sv
rtl/core/dwr_mem.sv
rtl/core/deque_with_rotation.sv
tb/deque_checker.sv
tb/testbench.sv
